>>> rtl/core/md5_hash_engine_macros.svh
// Assertion helpers for the checker module.
`ifndef MD5_HASH_ENGINE_MACROS_SVH
`define MD5_HASH_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MD5_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("md5_hash_engine: same-cycle property violated");

// Next-cycle implication, disabled while reset is asserted.
`define MD5_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("md5_hash_engine: next-cycle property violated");

`endif

>>> rtl/core/md5_pkg.sv
package md5_pkg;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data_byte;
    } t_in_req;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } t_out_req;

    localparam logic [1:0] CMD_ABSORB  = 2'd0;
    localparam logic [1:0] CMD_FINISH  = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // Per-round additive constant.
    function automatic logic [31:0] round_const(input logic [5:0] r);
        logic [31:0] k;
        unique case (r)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    // Left-rotate amount: depends on the round group and position within four.
    function automatic logic [4:0] rot_amt(input logic [5:0] r);
        logic [4:0] s;
        unique case ({r[5:4], r[1:0]})
            4'h0: s = 5'd7;   4'h1: s = 5'd12;  4'h2: s = 5'd17;  4'h3: s = 5'd22;
            4'h4: s = 5'd5;   4'h5: s = 5'd9;   4'h6: s = 5'd14;  4'h7: s = 5'd20;
            4'h8: s = 5'd4;   4'h9: s = 5'd11;  4'ha: s = 5'd16;  4'hb: s = 5'd23;
            4'hc: s = 5'd6;   4'hd: s = 5'd10;  4'he: s = 5'd15;  4'hf: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // Message word used by a round; all arithmetic is mod 16.
    function automatic logic [3:0] msg_index(input logic [5:0] r);
        logic [3:0] j;
        logic [3:0] g;
        j = r[3:0];
        unique case (r[5:4])
            2'd0: g = j;
            2'd1: g = 4'(j + (j << 2) + 4'd1);
            2'd2: g = 4'(j + (j << 1) + 4'd5);
            2'd3: g = 4'((j << 3) - j);
            default: g = j;
        endcase
        return g;
    endfunction

    // Boolean mixing function of the round group.
    function automatic logic [31:0] round_fn(input logic [1:0] grp,
                                             input logic [31:0] b,
                                             input logic [31:0] c,
                                             input logic [31:0] d);
        logic [31:0] f;
        unique case (grp)
            2'd0: f = (b & c) | (~b & d);
            2'd1: f = (b & d) | (c & ~d);
            2'd2: f = b ^ c ^ d;
            2'd3: f = c ^ (b | ~d);
            default: f = b;
        endcase
        return f;
    endfunction

endpackage

>>> rtl/core/md5_hash_engine.sv
// MD5 digest engine for a byte stream.
// Input channel (i_in_valid / o_in_stall / i_in_req): one request per item.
//   command ABSORB adds data_byte to the message, FINISH pads, appends the
//   bit length and emits the digest, RESTART drops the message in progress.
// Output channel (o_out_valid / i_out_stall / o_out_req): four requests per
//   FINISH, words A..D in order, last_word set on word D.
// Flow: an ABSORB leaves the engine idle, except the byte that completes a
//   64-byte block, which starts a compression (a read-ahead state, 64 rounds
//   at one per cycle, a chain-add state). The loop reads one message word
//   per cycle from the single-port-read block RAM; that loop sets the rate.
// A FINISH is accepted, writes the pad word, fills the later words up to
//   word 15 and runs a compression; when the pad byte falls at byte 56 or
//   later, a second block of sixteen fill words and a compression follow;
//   the four digest words then leave at one per cycle when not stalled.
// Reset loads the MD5 initial chain and a zero byte count; the block RAM is
//   not cleared, every word is written before a compression reads it.
// A stalled receiver holds the current word; the engine waits and keeps
//   o_in_stall high until the last word has entered the output register.
module md5_hash_engine
    import md5_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_req  i_in_req,
    output logic     o_in_stall,
    output logic     o_out_valid,
    output t_out_req o_out_req,
    input  logic     i_out_stall
);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a request
    localparam logic [2:0] S_PAD  = 3'd1;  // write the word holding the 0x80 pad
    localparam logic [2:0] S_FILL = 3'd2;  // zero / length words up to word 15
    localparam logic [2:0] S_CPRE = 3'd3;  // first RAM read in flight
    localparam logic [2:0] S_COMP = 3'd4;  // 64 rounds, one per cycle
    localparam logic [2:0] S_ADD  = 3'd5;  // fold working vars into the chain
    localparam logic [2:0] S_EMIT = 3'd6;  // push four digest words

    logic [2:0]  r_state, n_state;
    logic [5:0]  r_round, n_round;
    logic [3:0]  r_widx, n_widx;       // fill word pointer
    logic        r_two, n_two;         // finish needs an extra block
    logic        r_fin, n_fin;         // compression belongs to a finish
    logic [1:0]  r_emit_idx, n_emit_idx;
    logic [60:0] r_count, n_count;     // message bytes, wraps at 2^61
    logic [23:0] r_word, n_word;       // bytes of the word being assembled
    logic [31:0] r_chain [4];
    logic [31:0] n_chain [4];
    logic [31:0] r_wa, r_wb, r_wc, r_wd;
    logic [31:0] n_wa, n_wb, n_wc, n_wd;
    logic        r_out_valid, n_out_valid;
    t_out_req    r_out, n_out;

    // block RAM: sixteen little-endian message words
    logic        ram_we;
    logic [3:0]  ram_waddr;
    logic [31:0] ram_wdata;
    logic [3:0]  ram_raddr;
    logic [31:0] ram_rdata;

    logic [5:0]  pos;
    logic        accept;
    logic        out_free;
    logic [31:0] len_lo, len_hi;
    logic [31:0] word_ext;
    logic [31:0] pad_word;
    logic [31:0] fill_word;
    logic [31:0] f_val;
    logic [31:0] sum;
    logic [63:0] rot_wide;
    logic [31:0] new_b;

    md5_ram #(
        .WIDTH(32),
        .DEPTH(16)
    ) u_block_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign pos      = r_count[5:0];
    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign len_lo   = {r_count[28:0], 3'b000};
    assign len_hi   = r_count[60:29];
    assign word_ext = {8'h00, r_word};

    // pad word: earlier bytes of the partial word, 0x80, then zeros
    always_comb begin
        pad_word = '0;
        for (int k = 0; k < 4; k++) begin
            if (2'(k) < pos[1:0]) begin
                pad_word[8*k +: 8] = word_ext[8*k +: 8];
            end else if (2'(k) == pos[1:0]) begin
                pad_word[8*k +: 8] = PAD_BYTE;
            end
        end
    end

    // length goes into words 14/15 of the final block only
    always_comb begin
        fill_word = '0;
        if (!r_two && (r_widx == 4'd14)) begin
            fill_word = len_lo;
        end else if (!r_two && (r_widx == 4'd15)) begin
            fill_word = len_hi;
        end
    end

    // RAM write port
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = pos[5:2];
        ram_wdata = pad_word;
        priority if (accept && (i_in_req.command == CMD_ABSORB)
                     && (pos[1:0] == 2'd3)) begin
            ram_we    = 1'b1;
            ram_wdata = {i_in_req.data_byte, r_word};
        end else if (r_state == S_PAD) begin
            ram_we    = 1'b1;
        end else if (r_state == S_FILL) begin
            ram_we    = 1'b1;
            ram_waddr = r_widx;
            ram_wdata = fill_word;
        end else begin
            ram_we    = 1'b0;
        end
    end

    // read one round ahead; the data arrives with the round that uses it
    assign ram_raddr = (r_state == S_COMP) ? msg_index(6'(r_round + 6'd1))
                                           : msg_index(6'd0);

    // round datapath
    assign f_val    = round_fn(r_round[5:4], r_wb, r_wc, r_wd);
    assign sum      = r_wa + f_val + round_const(r_round) + ram_rdata;
    assign rot_wide = {sum, sum} << rot_amt(r_round);
    assign new_b    = r_wb + rot_wide[63:32];

    always_comb begin
        n_state     = r_state;
        n_round     = r_round;
        n_widx      = r_widx;
        n_two       = r_two;
        n_fin       = r_fin;
        n_emit_idx  = r_emit_idx;
        n_count     = r_count;
        n_word      = r_word;
        n_chain     = r_chain;
        n_wa        = r_wa;
        n_wb        = r_wb;
        n_wc        = r_wc;
        n_wd        = r_wd;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_in_req.command)
                        CMD_ABSORB: begin
                            n_count = 61'(r_count + 61'd1);
                            if (pos[1:0] != 2'd3) begin
                                n_word[{pos[1:0], 3'b000} +: 8] = i_in_req.data_byte;
                            end
                            if (pos == 6'd63) begin
                                n_fin   = 1'b0;
                                n_state = S_CPRE;
                            end
                        end
                        CMD_FINISH: begin
                            n_two   = (pos[5:3] == 3'b111);
                            n_state = S_PAD;
                        end
                        CMD_RESTART: begin
                            n_chain[0] = INIT_A;
                            n_chain[1] = INIT_B;
                            n_chain[2] = INIT_C;
                            n_chain[3] = INIT_D;
                            n_count    = '0;
                        end
                        default: begin
                            n_state = S_IDLE;  // unused command: dropped
                        end
                    endcase
                end
            end
            S_PAD: begin
                if (pos[5:2] == 4'd15) begin
                    n_fin   = 1'b1;
                    n_state = S_CPRE;
                end else begin
                    n_widx  = 4'(pos[5:2] + 4'd1);
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                if (r_widx == 4'd15) begin
                    n_fin   = 1'b1;
                    n_state = S_CPRE;
                end else begin
                    n_widx = 4'(r_widx + 4'd1);
                end
            end
            S_CPRE: begin
                n_wa    = r_chain[0];
                n_wb    = r_chain[1];
                n_wc    = r_chain[2];
                n_wd    = r_chain[3];
                n_round = '0;
                n_state = S_COMP;
            end
            S_COMP: begin
                n_wa    = r_wd;
                n_wb    = new_b;
                n_wc    = r_wb;
                n_wd    = r_wc;
                n_round = 6'(r_round + 6'd1);
                if (r_round == 6'd63) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                n_chain[0] = r_chain[0] + r_wa;
                n_chain[1] = r_chain[1] + r_wb;
                n_chain[2] = r_chain[2] + r_wc;
                n_chain[3] = r_chain[3] + r_wd;
                priority if (!r_fin) begin
                    n_state = S_IDLE;
                end else if (r_two) begin
                    // first of two finishing blocks done; build the length block
                    n_two   = 1'b0;
                    n_widx  = '0;
                    n_state = S_FILL;
                end else begin
                    n_emit_idx = '0;
                    n_state    = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.digest_word = r_chain[r_emit_idx];
                    n_out.word_index  = r_emit_idx;
                    n_out.last_word   = (r_emit_idx == 2'd3);
                    n_emit_idx        = 2'(r_emit_idx + 2'd1);
                    if (r_emit_idx == 2'd3) begin
                        n_chain[0] = INIT_A;
                        n_chain[1] = INIT_B;
                        n_chain[2] = INIT_C;
                        n_chain[3] = INIT_D;
                        n_count    = '0;
                        n_state    = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_round     <= '0;
            r_widx      <= '0;
            r_two       <= 1'b0;
            r_fin       <= 1'b0;
            r_emit_idx  <= '0;
            r_count     <= '0;
            r_chain[0]  <= INIT_A;
            r_chain[1]  <= INIT_B;
            r_chain[2]  <= INIT_C;
            r_chain[3]  <= INIT_D;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_round     <= n_round;
            r_widx      <= n_widx;
            r_two       <= n_two;
            r_fin       <= n_fin;
            r_emit_idx  <= n_emit_idx;
            r_count     <= n_count;
            r_chain     <= n_chain;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_wa   <= n_wa;
        r_wb   <= n_wb;
        r_wc   <= n_wc;
        r_wd   <= n_wd;
        r_out  <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

endmodule

>>> rtl/core/md5_ram.sv
module md5_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/md5_hash_engine_chk.sv
`include "md5_hash_engine_macros.svh"

module md5_hash_engine_chk
    import md5_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input t_in_req  i_in_req,
    input logic     o_in_stall,
    input logic     o_out_valid,
    input t_out_req o_out_req,
    input logic     i_out_stall
);

    // a stalled digest word stays offered
    `MD5_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)

    // last flag marks word D and only word D
    `MD5_ASSERT_IMPL(a_last_flag, i_clk, i_rst_n, o_out_valid, o_out_req.last_word == (o_out_req.word_index == 2'd3))

    // input stays closed while a digest is still being pushed out
    `MD5_ASSERT_IMPL(a_emit_busy, i_clk, i_rst_n, o_out_valid && !o_out_req.last_word, o_in_stall)

    // a finish request always occupies the engine on the next cycle
    `MD5_ASSERT_NEXT(a_finish_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall && (i_in_req.command == CMD_FINISH), o_in_stall)

    // a restart completes in its own cycle
    `MD5_ASSERT_NEXT(a_restart_fast, i_clk, i_rst_n, i_in_valid && !o_in_stall && (i_in_req.command == CMD_RESTART), !o_in_stall)

endmodule

bind md5_hash_engine md5_hash_engine_chk u_md5_chk (.*);
